>>> hdl/vector3_normalize_macros.svh
// Assertion macros used by the checker module.
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define V3N_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Condition that holds on every rising clock edge outside reset.
`define V3N_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

`endif

>>> hdl/v3n_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_pkg
// Widths and constants shared by the vector normalizer modules.
// ----------------------------------------------------------------------------
package v3n_pkg;
	localparam int COMP_W    = 32;
	localparam int MAG_W     = 33;
	localparam int SUM_W     = 67;
	localparam int LEN_W     = 34;
	localparam int UNIT_W    = 18;
	localparam int FRAC_BITS_DEFAULT = 16;
	localparam logic [UNIT_W-2:0] UNIT_MAX_MAG = '1;
endpackage

>>> hdl/v3n_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_sqrt
// Pipelined integer square root, one result bit per stage, with side data.
// ----------------------------------------------------------------------------
module v3n_sqrt
	import v3n_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [SUM_W-1:0]     radicand,
	input  logic [SIDE_W-1:0]    side_in,
	output logic                 out_valid,
	output logic [LEN_W-1:0]     root,
	output logic [SIDE_W-1:0]    side_out
);
	localparam int STEPS = LEN_W;

	// The radicand is widened to an even width so every stage takes a full pair.
	logic [STEPS:0]              vld_s;
	logic [2*STEPS-1:0]          rad_s  [STEPS+1];
	logic [LEN_W+1:0]            rem_s  [STEPS+1];
	logic [LEN_W-1:0]            root_s [STEPS+1];
	logic [SIDE_W-1:0]           side_s [STEPS+1];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = (2*STEPS)'(radicand);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [LEN_W+1:0] rem_sh;
		logic [LEN_W+1:0] trial;
		logic [1:0]       pair;
		always_comb begin
			pair   = rad_s[i][2*(STEPS-1-i) +: 2];
			rem_sh = {rem_s[i][LEN_W-1:0], pair};
			trial  = {root_s[i], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			rad_s[i+1]  <= rad_s[i];
			side_s[i+1] <= side_s[i];
			if (rem_sh >= trial) begin
				rem_s[i+1]  <= rem_sh - trial;
				root_s[i+1] <= {root_s[i][LEN_W-2:0], 1'b1};
			end else begin
				rem_s[i+1]  <= rem_sh;
				root_s[i+1] <= {root_s[i][LEN_W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign root      = root_s[STEPS];
	assign side_out  = side_s[STEPS];
endmodule

>>> hdl/v3n_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_div
// Pipelined restoring divider for one component, one quotient bit per stage.
// ----------------------------------------------------------------------------
module v3n_div
	import v3n_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
	parameter int QBITS     = MAG_W + FRAC_BITS
) (
	input  logic                 clk,
	input  logic [MAG_W-1:0]     mag,
	input  logic [COMP_W-1:0]    divisor,
	output logic [QBITS-1:0]     quot
);
	logic [QBITS-1:0]  num_s [QBITS+1];
	logic [COMP_W:0]   rem_s [QBITS+1];
	logic [COMP_W-1:0] den_s [QBITS+1];
	logic [QBITS-1:0]  q_s   [QBITS+1];

	assign num_s[0] = {mag, {FRAC_BITS{1'b0}}};
	assign rem_s[0] = '0;
	assign den_s[0] = divisor;
	assign q_s[0]   = '0;

	for (genvar i = 0; i < QBITS; i++) begin : g_step
		logic [COMP_W+1:0] sh;
		logic [COMP_W+1:0] diff;
		always_comb begin
			sh   = {rem_s[i], num_s[i][QBITS-1-i]};
			diff = sh - {2'b00, den_s[i]};
		end
		always_ff @(posedge clk) begin
			num_s[i+1] <= num_s[i];
			den_s[i+1] <= den_s[i];
			if (!diff[COMP_W+1]) begin
				rem_s[i+1] <= diff[COMP_W:0];
				q_s[i+1]   <= {q_s[i][QBITS-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= sh[COMP_W:0];
				q_s[i+1]   <= {q_s[i][QBITS-2:0], 1'b0};
			end
		end
	end

	assign quot = q_s[QBITS];
endmodule

>>> hdl/vector3_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize
// Length and unit direction of a signed Q16.16 three-component vector.
// ----------------------------------------------------------------------------
// Usage: drive vec_x, vec_y and vec_z and raise start; a beat is taken at
// every rising edge where start is high and busy is low. busy is always
// low here, so one vector can be taken in every cycle.
// Each beat yields one result beat: unit_x/y/z (signed, FRAC_BITS fraction
// bits), vec_length (floor of the Euclidean length, Q16.16) and zero_length,
// shown for exactly one cycle with done high. Results leave in order.
// Each result passes through the magnitude, square and sum stages, the
// bit-per-stage square root, the bit-per-stage dividers and the output register.
// Throughput is one vector per cycle.
// The receiver cannot stall; done beats must be captured when shown.
// Reset clears all valid bits, so no result appears until new beats enter.
// Stage 1 forms magnitudes, stage 2 squares them and stage 3 sums the squares.
// ----------------------------------------------------------------------------
module vector3_normalize
	import v3n_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [COMP_W-1:0]   vec_x,
	input  logic signed [COMP_W-1:0]   vec_y,
	input  logic signed [COMP_W-1:0]   vec_z,
	output logic                       done,
	output logic signed [UNIT_W-1:0]   unit_x,
	output logic signed [UNIT_W-1:0]   unit_y,
	output logic signed [UNIT_W-1:0]   unit_z,
	output logic [COMP_W-1:0]          vec_length,
	output logic                       zero_length
);
	localparam int QBITS = MAG_W + FRAC_BITS;
	localparam int SIDE_W = 3 * MAG_W + 3;
	localparam int DSIDE_W = 3 + LEN_W;

	logic                 vld_s1, vld_s2, vld_s3;
	logic [MAG_W-1:0]     mx_s1, my_s1, mz_s1;
	logic [2:0]           neg_s1;
	logic [2*MAG_W-1:0]   sqx_s2, sqy_s2, sqz_s2;
	logic [SUM_W-1:0]     sum_s3;
	logic [SIDE_W-1:0]    side_s2, side_s3;
	logic [MAG_W-1:0]     mx_s2, my_s2, mz_s2;
	logic [2:0]           neg_s2;

	assign busy = 1'b0;

	// Stage 1: magnitudes; -2^31 becomes 2^31 in 33 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1  <= vec_x[COMP_W-1] ? MAG_W'(-{vec_x[COMP_W-1], vec_x}) : MAG_W'(vec_x);
		my_s1  <= vec_y[COMP_W-1] ? MAG_W'(-{vec_y[COMP_W-1], vec_y}) : MAG_W'(vec_y);
		mz_s1  <= vec_z[COMP_W-1] ? MAG_W'(-{vec_z[COMP_W-1], vec_z}) : MAG_W'(vec_z);
		neg_s1 <= {vec_z[COMP_W-1], vec_y[COMP_W-1], vec_x[COMP_W-1]};
		// Stage 2: one square per component.
		sqx_s2  <= mx_s1 * mx_s1;
		sqy_s2  <= my_s1 * my_s1;
		sqz_s2  <= mz_s1 * mz_s1;
		side_s2 <= {neg_s1, mz_s1, my_s1, mx_s1};
		// Stage 3: sum of squares, exact in 67 bits.
		sum_s3  <= SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
		side_s3 <= side_s2;
	end

	// Square root pipeline carries magnitudes and signs alongside.
	logic              vld_r;
	logic [LEN_W-1:0]  root_r;
	logic [SIDE_W-1:0] side_r;

	v3n_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3), .radicand(sum_s3),
		.side_in(side_s3), .out_valid(vld_r), .root(root_r), .side_out(side_r)
	);

	assign {neg_s2, mz_s2, my_s2, mx_s2} = side_r;

	// Length fits 32 bits; a zero length divides by one and is masked later.
	logic [COMP_W-1:0] len_r, den_r;
	logic [QBITS-1:0]  qx, qy, qz;
	assign len_r = root_r[COMP_W-1:0];
	assign den_r = (len_r == '0) ? COMP_W'(1) : len_r;

	v3n_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk(clk), .mag(mx_s2), .divisor(den_r), .quot(qx));
	v3n_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk(clk), .mag(my_s2), .divisor(den_r), .quot(qy));
	v3n_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
		.clk(clk), .mag(mz_s2), .divisor(den_r), .quot(qz));

	// Valid, signs and length ride a delay line matched to the dividers.
	logic [QBITS:0]     dvld_s;
	logic [DSIDE_W-1:0] dside_s [QBITS+1];
	assign dvld_s[0]  = vld_r;
	assign dside_s[0] = {neg_s2, root_r};

	for (genvar i = 0; i < QBITS; i++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[i+1] <= 1'b0;
			end else begin
				dvld_s[i+1] <= dvld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			dside_s[i+1] <= dside_s[i];
		end
	end

	logic [2:0]        negd;
	logic [LEN_W-1:0]  lend;
	logic              zerod;
	assign {negd, lend} = dside_s[QBITS];
	assign zerod = (lend[COMP_W-1:0] == '0);

	function automatic logic [UNIT_W-1:0] fmt_unit(input logic [QBITS-1:0] q,
		input logic neg, input logic zero);
		logic [UNIT_W-1:0] m;
		begin
			m = (q > QBITS'(UNIT_MAX_MAG)) ? {1'b0, UNIT_MAX_MAG} : q[UNIT_W-1:0];
			fmt_unit = zero ? '0 : (neg ? -m : m);
		end
	endfunction

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dvld_s[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		unit_x      <= fmt_unit(qx, negd[0], zerod);
		unit_y      <= fmt_unit(qy, negd[1], zerod);
		unit_z      <= fmt_unit(qz, negd[2], zerod);
		vec_length  <= lend[COMP_W-1:0];
		zero_length <= zerod;
	end
endmodule

>>> hdl/v3n_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3n_checker
// Port-level checks on the vector normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "vector3_normalize_macros.svh"

module v3n_checker
	import v3n_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic signed [UNIT_W-1:0] unit_x,
	input logic signed [UNIT_W-1:0] unit_y,
	input logic signed [UNIT_W-1:0] unit_z,
	input logic [COMP_W-1:0]        vec_length,
	input logic                     zero_length
);
	logic start_seen;
	assign start_seen = start;

	`V3N_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy || !start_seen)
	`V3N_ASSERT_IMPL(a_zero_flag, clk, arst_n, done, zero_length == (vec_length == '0))
	`V3N_ASSERT_IMPL(a_zero_units, clk, arst_n, done && zero_length,
		unit_x == '0 && unit_y == '0 && unit_z == '0)
	`V3N_ASSERT_IMPL(a_unit_bound, clk, arst_n, done && !zero_length,
		unit_x <= 18'sd65536 && unit_x >= -18'sd65536)
endmodule

bind vector3_normalize v3n_checker u_v3n_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
	.vec_length(vec_length), .zero_length(zero_length)
);

>>> bench/vector3_normalize_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_tb
// Self-checking bench for the pipelined vector normalizer.
// A short table of directed vectors is walked first. Random vectors follow,
// with three idling phases on the sending side. Every result beat is checked
// field by field against a behavioral model of length and unit direction,
// in the order in which the input beats were taken.
// ----------------------------------------------------------------------------
module vector3_normalize_tb;
	import v3n_pkg::*;

	// One result beat as the block presents it.
	typedef struct packed {
		logic signed [UNIT_W-1:0] ux;
		logic signed [UNIT_W-1:0] uy;
		logic signed [UNIT_W-1:0] uz;
		logic [COMP_W-1:0]        len;
		logic                     zero;
	} norm_result_t;

	// A row of the directed table. When has_exp is set, the typed-in result
	// is checked as well as the model's prediction.
	typedef struct {
		logic signed [COMP_W-1:0] x, y, z;
		bit                       has_exp;
		norm_result_t             exp;
	} vec_row_t;

	localparam int LATENCY   = 3 + 34 + 33 + FRAC_BITS_DEFAULT + 1;
	localparam int N_RANDOM  = 600;
	localparam longint LIMIT = 200000;
	localparam logic signed [COMP_W-1:0] MOST_NEG = 32'sh8000_0000;
	localparam logic signed [COMP_W-1:0] MOST_POS = 32'sh7FFF_FFFF;
	localparam logic signed [UNIT_W-1:0] UNIT_ONE = 18'sd65536;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [COMP_W-1:0] vec_x, vec_y, vec_z;
	logic                     done;
	logic signed [UNIT_W-1:0] unit_x, unit_y, unit_z;
	logic [COMP_W-1:0]        vec_length;
	logic                     zero_length;

	norm_result_t pending_norms[$];
	norm_result_t typed_norms[$];
	bit           typed_valid[$];
	int           mismatch_count;
	longint       cycle_count;
	int           send_idle_pct;

	vector3_normalize dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.done(done), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.vec_length(vec_length), .zero_length(zero_length)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Magnitude of a component; the most negative value gives 2^31 exactly.
	function automatic logic [MAG_W-1:0] comp_mag(logic signed [COMP_W-1:0] v);
		logic [MAG_W-1:0] w;
		w = {v[COMP_W-1], v};
		return v[COMP_W-1] ? -w : w;
	endfunction

	// Floor of the square root of the sum of squares, one result bit per pass.
	function automatic logic [LEN_W-1:0] floor_sqrt(logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] root;
		logic [SUM_W-1:0] trial;
		root = '0;
		for (int b = LEN_W - 1; b >= 0; b--) begin
			trial = root | (67'd1 << b);
			if (trial * trial <= s)
				root = trial;
		end
		return root[LEN_W-1:0];
	endfunction

	// Quotient with FRAC_BITS fraction bits, saturated, then signed.
	function automatic logic signed [UNIT_W-1:0] unit_of(logic [MAG_W-1:0] m,
		logic neg, logic [LEN_W-1:0] len);
		logic [SUM_W-1:0] q;
		q = ({34'd0, m} << FRAC_BITS_DEFAULT) / len;
		if (q > UNIT_MAX_MAG)
			q = UNIT_MAX_MAG;
		return neg ? -q[UNIT_W-1:0] : q[UNIT_W-1:0];
	endfunction

	function automatic norm_result_t predict_norm(logic signed [COMP_W-1:0] x,
		logic signed [COMP_W-1:0] y, logic signed [COMP_W-1:0] z);
		norm_result_t r;
		logic [MAG_W-1:0] mx, my, mz;
		logic [SUM_W-1:0] sum;
		logic [LEN_W-1:0] len;
		mx = comp_mag(x);
		my = comp_mag(y);
		mz = comp_mag(z);
		sum = SUM_W'(mx) * mx + SUM_W'(my) * my + SUM_W'(mz) * mz;
		len = floor_sqrt(sum) & 34'hFFFF_FFFF;
		if (len == 0) begin
			r = '0;
			r.zero = 1'b1;
		end else begin
			r.ux = unit_of(mx, x[COMP_W-1], len);
			r.uy = unit_of(my, y[COMP_W-1], len);
			r.uz = unit_of(mz, z[COMP_W-1], len);
			r.len = len[COMP_W-1:0];
			r.zero = 1'b0;
		end
		return r;
	endfunction

	function automatic norm_result_t mk_res(logic signed [UNIT_W-1:0] ux,
		logic signed [UNIT_W-1:0] uy, logic signed [UNIT_W-1:0] uz,
		logic [COMP_W-1:0] len, logic zero);
		norm_result_t r;
		r.ux = ux;
		r.uy = uy;
		r.uz = uz;
		r.len = len;
		r.zero = zero;
		return r;
	endfunction

	task automatic report_mismatch(string what, norm_result_t e, norm_result_t a);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display({"mismatch (%s) at cycle %0d: expected %0d %0d %0d len %0d ",
				"zero %0b, got %0d %0d %0d len %0d zero %0b"},
				what, cycle_count, e.ux, e.uy, e.uz, e.len, e.zero,
				a.ux, a.uy, a.uz, a.len, a.zero);
	endtask

	// Result checker: every done beat is matched with the oldest prediction.
	always @(posedge clk) begin
		norm_result_t got;
		norm_result_t want;
		norm_result_t typed;
		bit           typed_ok;
		cycle_count <= cycle_count + 1;
		if (arst_n && done) begin
			got = mk_res(unit_x, unit_y, unit_z, vec_length, zero_length);
			if (pending_norms.size() == 0) begin
				report_mismatch("no beat pending", '0, got);
			end else begin
				want = pending_norms.pop_front();
				typed = typed_norms.pop_front();
				typed_ok = typed_valid.pop_front();
				if (got !== want)
					report_mismatch("model", want, got);
				if (typed_ok && got !== typed)
					report_mismatch("table", typed, got);
			end
		end
	end

	// A hard limit on the run, whatever state the block is left in.
	always @(posedge clk) begin
		if (cycle_count > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Sends one beat: present it at the falling edge and hold it until it is
	// taken at a rising edge with busy low. The prediction is queued when the
	// beat is taken, so the checker never sees a result before it.
	task automatic send_vec(logic signed [COMP_W-1:0] x, logic signed [COMP_W-1:0] y,
		logic signed [COMP_W-1:0] z, bit has_exp, norm_result_t exp);
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		pending_norms.push_back(predict_norm(x, y, z));
		typed_norms.push_back(exp);
		typed_valid.push_back(has_exp);
		@(negedge clk);
		// Each cycle idles with the phase's chance; start stays high across
		// back-to-back beats.
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
	endtask

	// Random component: often full range, with extremes, small values and shifted values mixed in.
	function automatic logic signed [COMP_W-1:0] rand_comp();
		case ($urandom_range(7))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return $signed($urandom_range(0, 3)) - 1;
			3: return $signed($urandom_range(0, 131072)) - 65536;
			4: return 32'($urandom) >>> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (pending_norms.size() != 0 && guard < 10 * LATENCY) begin
			@(negedge clk);
			guard++;
		end
	endtask

	vec_row_t table_rows[$];

	initial begin
		vec_row_t row;
		norm_result_t none;
		none = '0;
		arst_n = 1'b0;
		start = 1'b0;
		vec_x = '0;
		vec_y = '0;
		vec_z = '0;
		mismatch_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;

		// Directed table: zero vector, unit axes, extremes, sign mix.
		table_rows = '{
			'{32'sd0, 32'sd0, 32'sd0, 1'b1, mk_res('0, '0, '0, '0, 1'b1)},
			'{32'sd65536, 32'sd0, 32'sd0, 1'b1,
				mk_res(UNIT_ONE, '0, '0, 32'd65536, 1'b0)},
			'{32'sd0, -32'sd65536, 32'sd0, 1'b1,
				mk_res('0, -UNIT_ONE, '0, 32'd65536, 1'b0)},
			'{32'sd0, 32'sd0, 32'sd1, 1'b1, mk_res('0, '0, UNIT_ONE, 32'd1, 1'b0)},
			'{MOST_NEG, 32'sd0, 32'sd0, 1'b1,
				mk_res(-UNIT_ONE, '0, '0, 32'h8000_0000, 1'b0)},
			'{32'sd0, MOST_POS, 32'sd0, 1'b1,
				mk_res('0, UNIT_ONE, '0, 32'h7FFF_FFFF, 1'b0)},
			'{32'sd0, 32'sd0, MOST_NEG, 1'b1,
				mk_res('0, '0, -UNIT_ONE, 32'h8000_0000, 1'b0)},
			'{MOST_NEG, MOST_NEG, MOST_NEG, 1'b0, none},
			'{MOST_POS, MOST_POS, MOST_POS, 1'b0, none},
			'{MOST_NEG, MOST_POS, MOST_NEG, 1'b0, none},
			'{-32'sd1, -32'sd1, -32'sd1, 1'b0, none},
			'{32'sd1, -32'sd1, 32'sd0, 1'b0, none},
			'{32'sd196608, 32'sd262144, 32'sd0, 1'b0, none},
			'{-32'sd3, 32'sd4, -32'sd12, 1'b0, none},
			'{32'sd65536, 32'sd65536, 32'sd65536, 1'b0, none},
			'{-32'sd65536, 32'sd0, 32'sd65536, 1'b0, none},
			'{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678, 1'b0, none}
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (table_rows[i]) begin
			row = table_rows[i];
			send_vec(row.x, row.y, row.z, row.has_exp, row.exp);
		end
		start <= 1'b0;
		// Let the pipeline drain completely before the random part.
		wait_drained();

		for (int n = 0; n < N_RANDOM; n++) begin
			// Three phases: sender idles rarely, often, then never.
			if (n < N_RANDOM / 3)
				send_idle_pct = 19;
			else if (n < 2 * N_RANDOM / 3)
				send_idle_pct = 78;
			else
				send_idle_pct = 0;
			send_vec(rand_comp(), rand_comp(), rand_comp(), 1'b0, none);
		end
		start <= 1'b0;

		wait_drained();
		repeat (LATENCY + 10) @(negedge clk);
		if (mismatch_count == 0 && pending_norms.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

>>> vector3_normalize.f
+incdir+hdl
hdl/v3n_pkg.sv
hdl/v3n_sqrt.sv
hdl/v3n_div.sv
hdl/vector3_normalize.sv
hdl/v3n_checker.sv
bench/vector3_normalize_tb.sv
